@@ src/dedup_priority_display_queue_defines.svh @@
// assertion macros for the dedup priority display queue
`ifndef DEDUP_PRIORITY_DISPLAY_QUEUE_DEFINES_SVH
`define DEDUP_PRIORITY_DISPLAY_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define DPDQ_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("dpdq assertion failed");
`define DPDQ_ASSERT_IMPL(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("dpdq assertion failed");
`define DPDQ_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("dpdq assertion failed");
`else
`define DPDQ_ASSERT_ALWAYS(label, clk, rst, cond)
`define DPDQ_ASSERT_IMPL(label, clk, rst, a, c)
`define DPDQ_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

@@ src/dpdq_pkg.sv @@
// shared types and codes of the dedup priority display queue
package dpdq_pkg;

   localparam int ACTIVE_DEPTH_DEF  = 8;
   localparam int PENDING_DEPTH_DEF = 16;

   localparam logic [2:0] ACT_ADMIT     = 3'd0;
   localparam logic [2:0] ACT_PROMOTE   = 3'd1;
   localparam logic [2:0] ACT_REMOVE_A  = 3'd2;
   localparam logic [2:0] ACT_REMOVE_P  = 3'd3;
   localparam logic [2:0] ACT_CLEAR     = 3'd4;

   localparam logic [3:0] ST_SHOWN      = 4'd0;
   localparam logic [3:0] ST_QUEUED     = 4'd1;
   localparam logic [3:0] ST_DEDUP_HIT  = 4'd2;
   localparam logic [3:0] ST_DROPPED    = 4'd3;
   localparam logic [3:0] ST_PROMOTED   = 4'd4;
   localparam logic [3:0] ST_NO_PROMOTE = 4'd5;
   localparam logic [3:0] ST_REMOVED    = 4'd6;
   localparam logic [3:0] ST_NOT_FOUND  = 4'd7;
   localparam logic [3:0] ST_CLEARED    = 4'd8;

   localparam logic REG_MAX_VISIBLE = 1'b0;

   typedef struct packed {
      logic [31:0] handle;
      logic [31:0] key;
      logic        key_present;
      logic [7:0]  prio;
   } entry_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [31:0] handle;
      logic [31:0] key;
      logic        key_present;
      logic [7:0]  prio;
   } result_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_A_SCAN,
      S_P_SCAN,
      S_PLACE,
      S_INSERT,
      S_PROMOTE,
      S_PURGE_A,
      S_PURGE_P,
      S_DONE
   } state_type;

endpackage

@@ src/dpdq_req_if.sv @@
// request channel of the dedup priority display queue
interface dpdq_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [31:0] handle_id;
   logic [31:0] dedup_key;
   logic        key_present;
   logic [7:0]  priority_req;

   modport source(output valid, action, handle_id, dedup_key, key_present, priority_req,
                  input ready);
   modport sink(input valid, action, handle_id, dedup_key, key_present, priority_req,
                output ready);
endinterface

@@ src/dpdq_rsp_if.sv @@
// response channel of the dedup priority display queue
interface dpdq_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [31:0] handle_out;
   logic [31:0] key_out;
   logic        key_present_out;
   logic [7:0]  priority_out;

   modport source(output valid, status, handle_out, key_out, key_present_out, priority_out,
                  input ready);
   modport sink(input valid, status, handle_out, key_out, key_present_out, priority_out,
                output ready);
endinterface

@@ src/dedup_priority_display_queue.sv @@
// top level of the dedup priority display queue
// usage:
//  - req_if carries one request (admit, promote, remove active, remove pending,
//    clear) with valid/ready; rsp_if returns exactly one response per request
//  - apb-style port sets max_visible (byte address 0); write only while idle
//  - one request at a time: a small sequencer walks the entry lists one entry
//    per cycle through a single read port per list
//  - admit with a key scans active then pending entries, then may shift the
//    pending list one entry a cycle to open its slot; promote slides the
//    pending list up and removes compact their list; clear and unknown codes
//    go from idle straight to the done state
//  - the response waits in an output register; a new request is taken as soon
//    as the sequencer is back in idle, even while the last response is held
//  - a stalled receiver holds the response; a finished request then waits in
//    the done state until the output register frees up
//  - reset (synchronous) empties both lists, sets max_visible to 1 and drops
//    any held response; entry storage is not cleared
`include "dedup_priority_display_queue_defines.svh"
module dedup_priority_display_queue #(
   parameter int ACTIVE_DEPTH  = dpdq_pkg::ACTIVE_DEPTH_DEF,
   parameter int PENDING_DEPTH = dpdq_pkg::PENDING_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   dpdq_req_if.sink          req_if,
   dpdq_rsp_if.source        rsp_if,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [0:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   localparam int AIW = (ACTIVE_DEPTH > 1) ? $clog2(ACTIVE_DEPTH) : 1;
   localparam int PIW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int ACW = $clog2(ACTIVE_DEPTH + 1);
   localparam int PCW = $clog2(PENDING_DEPTH + 1);
   localparam int CW  = (PCW > ACW) ? PCW : ACW;

   dpdq_pkg::state_type  state_ff, state_in;
   logic [3:0]           mv_ff;
   logic [ACW-1:0]       ac_ff, ac_in;
   logic [PCW-1:0]       pc_ff, pc_in;
   logic [CW-1:0]        idx_ff, idx_in;   // scan / read pointer
   logic [CW-1:0]        wp_ff, wp_in;     // compaction write pointer
   logic [2:0]           act_ff, act_in;
   dpdq_pkg::entry_type  item_ff, item_in;
   dpdq_pkg::result_type res_ff, res_in;
   dpdq_pkg::result_type rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // list ports
   logic                a_we, p_we;
   logic [AIW-1:0]      a_waddr, a_raddr;
   logic [PIW-1:0]      p_waddr, p_raddr;
   dpdq_pkg::entry_type a_wdata, p_wdata, a_rd, p_rd;

   logic                acc, slot_free;
   logic [ACW-1:0]      lim;
   logic                a_room, p_room;
   logic                a_end, p_end, a_hit, p_hit, shift_more;
   logic                w_hold;
   dpdq_pkg::entry_type head;

   dpdq_list #(.DEPTH(ACTIVE_DEPTH)) u_active (
      .clock(clock), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
      .raddr(a_raddr), .rdata(a_rd));

   dpdq_list #(.DEPTH(PENDING_DEPTH)) u_pending (
      .clock(clock), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
      .raddr(p_raddr), .rdata(p_rd));

   // config port
   assign pready = 1'b1;
   assign prdata = (paddr == dpdq_pkg::REG_MAX_VISIBLE) ? {28'd0, mv_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 4'd1;
      end else if (psel && penable && pwrite && paddr == dpdq_pkg::REG_MAX_VISIBLE) begin
         mv_ff <= pwdata[3:0];
      end
   end

   // visible limit, clamped to 1..ACTIVE_DEPTH
   always_comb begin
      if (mv_ff == 4'd0) begin
         lim = ACW'(1);
      end else if (32'(mv_ff) > ACTIVE_DEPTH) begin
         lim = ACW'(ACTIVE_DEPTH);
      end else begin
         lim = ACW'(mv_ff);
      end
   end

   assign acc       = req_if.valid && req_if.ready;
   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign a_room    = ac_ff < lim;
   assign p_room    = 32'(pc_ff) < PENDING_DEPTH;
   assign a_end     = idx_ff == CW'(ac_ff);
   assign p_end     = idx_ff == CW'(pc_ff);
   // keyless entries are stored with key zero and never match
   assign a_hit     = !a_end && a_rd.key_present && a_rd.key == item_ff.key;
   assign p_hit     = !p_end && p_rd.key_present && p_rd.key == item_ff.key;
   // insertion walks down from the tail while the entry above has lower priority
   assign shift_more = (idx_ff != '0) && (p_rd.prio < item_ff.prio);
   assign w_hold    = a_rd.handle == item_ff.handle;
   assign head      = '{handle: res_ff.handle, key: res_ff.key,
                        key_present: res_ff.key_present, prio: res_ff.prio};

   assign req_if.ready = state_ff == dpdq_pkg::S_IDLE;

   // read addresses: the stores register the read, so the address for the
   // next state goes out now; idle and done keep the pending head on p_rd
   always_comb begin
      a_raddr = idx_in[AIW-1:0];
      p_raddr = idx_in[PIW-1:0];
      unique case (state_in) inside
         dpdq_pkg::S_IDLE, dpdq_pkg::S_DONE: p_raddr = '0;
         dpdq_pkg::S_INSERT:                 p_raddr = PIW'(idx_in - CW'(1));
         default:                            p_raddr = idx_in[PIW-1:0];
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dpdq_pkg::S_IDLE: begin
            if (acc) begin
               unique case (req_if.action)
                  dpdq_pkg::ACT_ADMIT:
                     state_in = req_if.key_present ? dpdq_pkg::S_A_SCAN : dpdq_pkg::S_PLACE;
                  dpdq_pkg::ACT_PROMOTE:
                     state_in = (pc_ff == '0 || !a_room) ? dpdq_pkg::S_DONE
                                                         : dpdq_pkg::S_PROMOTE;
                  dpdq_pkg::ACT_REMOVE_A: state_in = dpdq_pkg::S_PURGE_A;
                  dpdq_pkg::ACT_REMOVE_P: state_in = dpdq_pkg::S_PURGE_P;
                  default:                state_in = dpdq_pkg::S_DONE;
               endcase
            end
         end
         dpdq_pkg::S_A_SCAN: begin
            if (a_hit) begin
               state_in = dpdq_pkg::S_DONE;
            end else if (a_end) begin
               state_in = dpdq_pkg::S_P_SCAN;
            end
         end
         dpdq_pkg::S_P_SCAN: begin
            if (p_hit) begin
               state_in = dpdq_pkg::S_DONE;
            end else if (p_end) begin
               state_in = dpdq_pkg::S_PLACE;
            end
         end
         dpdq_pkg::S_PLACE: begin
            state_in = (!a_room && p_room) ? dpdq_pkg::S_INSERT : dpdq_pkg::S_DONE;
         end
         dpdq_pkg::S_INSERT: begin
            if (!shift_more) begin
               state_in = dpdq_pkg::S_DONE;
            end
         end
         dpdq_pkg::S_PROMOTE: begin
            if (p_end) begin
               state_in = dpdq_pkg::S_DONE;
            end
         end
         dpdq_pkg::S_PURGE_A: begin
            if (a_end) begin
               state_in = dpdq_pkg::S_DONE;
            end
         end
         dpdq_pkg::S_PURGE_P: begin
            if (p_end) begin
               state_in = dpdq_pkg::S_DONE;
            end
         end
         dpdq_pkg::S_DONE: begin
            if (slot_free) begin
               state_in = dpdq_pkg::S_IDLE;
            end
         end
         default: state_in = dpdq_pkg::S_IDLE;
      endcase
   end

   // datapath and list writes
   always_comb begin
      idx_in  = idx_ff;
      wp_in   = wp_ff;
      ac_in   = ac_ff;
      pc_in   = pc_ff;
      act_in  = act_ff;
      item_in = item_ff;
      res_in  = res_ff;
      a_we    = 1'b0;
      a_waddr = ac_ff[AIW-1:0];
      a_wdata = item_ff;
      p_we    = 1'b0;
      p_waddr = idx_ff[PIW-1:0];
      p_wdata = item_ff;
      unique case (state_ff)
         dpdq_pkg::S_IDLE: begin
            if (acc) begin
               act_in  = req_if.action;
               item_in = '{handle: req_if.handle_id,
                           key: req_if.key_present ? req_if.dedup_key : 32'd0,
                           key_present: req_if.key_present,
                           prio: req_if.priority_req};
               res_in  = '0;
               idx_in  = '0;
               wp_in   = '0;
               unique case (req_if.action) inside
                  dpdq_pkg::ACT_PROMOTE: begin
                     if (pc_ff == '0 || !a_room) begin
                        res_in.status = dpdq_pkg::ST_NO_PROMOTE;
                     end else begin
                        // latch the head, then slide the rest up from index 1
                        res_in = '{status: dpdq_pkg::ST_PROMOTED, handle: p_rd.handle,
                                   key: p_rd.key, key_present: p_rd.key_present,
                                   prio: p_rd.prio};
                        idx_in = CW'(1);
                     end
                  end
                  dpdq_pkg::ACT_CLEAR: begin
                     ac_in         = '0;
                     pc_in         = '0;
                     res_in.status = dpdq_pkg::ST_CLEARED;
                  end
                  dpdq_pkg::ACT_ADMIT, dpdq_pkg::ACT_REMOVE_A, dpdq_pkg::ACT_REMOVE_P: ;
                  default: res_in.status = dpdq_pkg::ST_NOT_FOUND;
               endcase
            end
         end
         dpdq_pkg::S_A_SCAN: begin
            if (a_hit) begin
               res_in.status = dpdq_pkg::ST_DEDUP_HIT;
               res_in.handle = a_rd.handle;
            end else if (a_end) begin
               idx_in = '0;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         dpdq_pkg::S_P_SCAN: begin
            if (p_hit) begin
               res_in.status = dpdq_pkg::ST_DEDUP_HIT;
               res_in.handle = p_rd.handle;
            end else if (!p_end) begin
               idx_in = idx_ff + CW'(1);
            end
         end
         dpdq_pkg::S_PLACE: begin
            if (a_room) begin
               a_we          = 1'b1;
               ac_in         = ac_ff + ACW'(1);
               res_in.status = dpdq_pkg::ST_SHOWN;
            end else if (p_room) begin
               idx_in = CW'(pc_ff);
            end else begin
               res_in.status = dpdq_pkg::ST_DROPPED;
            end
         end
         dpdq_pkg::S_INSERT: begin
            p_we = 1'b1;
            if (shift_more) begin
               p_wdata = p_rd;
               idx_in  = idx_ff - CW'(1);
            end else begin
               pc_in         = pc_ff + PCW'(1);
               res_in.status = dpdq_pkg::ST_QUEUED;
            end
         end
         dpdq_pkg::S_PROMOTE: begin
            if (p_end) begin
               pc_in   = pc_ff - PCW'(1);
               a_we    = 1'b1;
               a_wdata = head;
               ac_in   = ac_ff + ACW'(1);
            end else begin
               p_we    = 1'b1;
               p_waddr = PIW'(idx_ff - CW'(1));
               p_wdata = p_rd;
               idx_in  = idx_ff + CW'(1);
            end
         end
         dpdq_pkg::S_PURGE_A: begin
            a_waddr = wp_ff[AIW-1:0];
            a_wdata = a_rd;
            if (a_end) begin
               ac_in         = ACW'(wp_ff);
               res_in.status = (wp_ff != CW'(ac_ff)) ? dpdq_pkg::ST_REMOVED
                                                     : dpdq_pkg::ST_NOT_FOUND;
            end else begin
               idx_in = idx_ff + CW'(1);
               if (!w_hold) begin
                  a_we  = 1'b1;
                  wp_in = wp_ff + CW'(1);
               end
            end
         end
         dpdq_pkg::S_PURGE_P: begin
            p_waddr = wp_ff[PIW-1:0];
            p_wdata = p_rd;
            if (p_end) begin
               pc_in         = PCW'(wp_ff);
               res_in.status = (wp_ff != CW'(pc_ff)) ? dpdq_pkg::ST_REMOVED
                                                     : dpdq_pkg::ST_NOT_FOUND;
            end else begin
               idx_in = idx_ff + CW'(1);
               if (p_rd.handle != item_ff.handle) begin
                  p_we  = 1'b1;
                  wp_in = wp_ff + CW'(1);
               end
            end
         end
         default: ;
      endcase
   end

   // response register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == dpdq_pkg::S_DONE && slot_free) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dpdq_pkg::S_IDLE;
         ac_ff        <= '0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ac_ff        <= ac_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      wp_ff   <= wp_in;
      act_ff  <= act_in;
      item_ff <= item_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.status          = rsp_ff.status;
   assign rsp_if.handle_out      = rsp_ff.handle;
   assign rsp_if.key_out         = rsp_ff.key;
   assign rsp_if.key_present_out = rsp_ff.key_present;
   assign rsp_if.priority_out    = rsp_ff.prio;

   `DPDQ_ASSERT_ALWAYS(a_active_bound, clock, reset, 32'(ac_ff) <= ACTIVE_DEPTH)
   `DPDQ_ASSERT_ALWAYS(a_pending_bound, clock, reset, 32'(pc_ff) <= PENDING_DEPTH)
   `DPDQ_ASSERT_NEXT(a_done_emits, clock, reset, state_ff == dpdq_pkg::S_DONE && slot_free, rsp_valid_ff && state_ff == dpdq_pkg::S_IDLE)
   `DPDQ_ASSERT_NEXT(a_clear_empties, clock, reset, acc && req_if.action == dpdq_pkg::ACT_CLEAR, ac_ff == '0 && pc_ff == '0)
   `DPDQ_ASSERT_IMPL(a_busy_blocks, clock, reset, state_ff != dpdq_pkg::S_IDLE, !req_if.ready)
   `DPDQ_ASSERT_IMPL(a_remove_kept_count, clock, reset, act_ff == dpdq_pkg::ACT_REMOVE_P && state_ff == dpdq_pkg::S_PURGE_P, wp_ff <= idx_ff)
endmodule

@@ src/dpdq_list.sv @@
// entry store with one read and one write address per cycle
module dpdq_list #(
   parameter int DEPTH = dpdq_pkg::ACTIVE_DEPTH_DEF,
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                we,
   input  logic [IW-1:0]       waddr,
   input  dpdq_pkg::entry_type wdata,
   input  logic [IW-1:0]       raddr,
   output dpdq_pkg::entry_type rdata
);
   dpdq_pkg::entry_type mem_ff [DEPTH];
   dpdq_pkg::entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read, data follows the address in the next cycle
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ tb/tb_dedup_priority_display_queue.sv @@
// self-checking testbench for the dedup priority display queue
`timescale 1ns / 100ps
module tb_dedup_priority_display_queue;

   // codes outside the defined operations
   localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
   localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
   localparam int A_DEPTH   = dpdq_pkg::ACTIVE_DEPTH_DEF;
   localparam int P_DEPTH   = dpdq_pkg::PENDING_DEPTH_DEF;
   localparam int MAX_CYCLES = 1000000;
   localparam int PHASE_REQS = 190;

   typedef struct {
      logic [2:0]  act;
      logic [31:0] handle;
      logic [31:0] key;
      logic        key_present;
      logic [7:0]  prio;
   } request_type;

   // directed row: expected status/handle typed in where obvious
   typedef struct {
      request_type req;
      bit          typed;
      logic [3:0]  status;
      logic [31:0] handle;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [0:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   dpdq_req_if req_ch();
   dpdq_rsp_if rsp_ch();

   dedup_priority_display_queue dut (
      .clock(clock), .reset(reset), .req_if(req_ch), .rsp_if(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #10 clock = ~clock;

   // predictor copy of the lists and the visible limit
   logic [31:0] act_handle [A_DEPTH];
   logic [32:0] act_key    [A_DEPTH];
   logic [7:0]  act_prio   [A_DEPTH];
   int          act_count;
   logic [31:0] pend_handle [P_DEPTH];
   logic [32:0] pend_key    [P_DEPTH];
   logic [7:0]  pend_prio   [P_DEPTH];
   int          pend_count;
   logic [3:0]  visible_cfg;

   dpdq_pkg::result_type expected_rsps[$];
   int errors = 0;
   int cycles = 0;
   int sender_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;

   // works out the response of one request and updates the lists
   function automatic dpdq_pkg::result_type predict_queue(request_type rq);
      dpdq_pkg::result_type r;
      logic [32:0] kk;
      int lim;
      int pos;
      int w;
      int n;
      bit hit;
      r = '0;
      hit = 1'b0;
      kk = rq.key_present ? {1'b1, rq.key} : 33'd0;
      lim = (visible_cfg == 0) ? 1 : (visible_cfg > A_DEPTH) ? A_DEPTH : visible_cfg;
      case (rq.act)
         dpdq_pkg::ACT_ADMIT: begin
            // keyless entries never match; active list searched first
            if (rq.key_present) begin
               for (int i = 0; i < act_count; i++)
                  if (!hit && act_key[i] == kk) begin
                     hit = 1'b1;
                     r.handle = act_handle[i];
                  end
               for (int i = 0; i < pend_count; i++)
                  if (!hit && pend_key[i] == kk) begin
                     hit = 1'b1;
                     r.handle = pend_handle[i];
                  end
            end
            if (hit) begin
               r.status = dpdq_pkg::ST_DEDUP_HIT;
            end else if (act_count < lim) begin
               act_handle[act_count] = rq.handle;
               act_key[act_count] = kk;
               act_prio[act_count] = rq.prio;
               act_count++;
               r.status = dpdq_pkg::ST_SHOWN;
            end else if (pend_count < P_DEPTH) begin
               // insert behind every entry of equal or higher priority
               pos = 0;
               while (pos < pend_count && pend_prio[pos] >= rq.prio) pos++;
               for (int j = pend_count; j > pos; j--) begin
                  pend_handle[j] = pend_handle[j-1];
                  pend_key[j] = pend_key[j-1];
                  pend_prio[j] = pend_prio[j-1];
               end
               pend_handle[pos] = rq.handle;
               pend_key[pos] = kk;
               pend_prio[pos] = rq.prio;
               pend_count++;
               r.status = dpdq_pkg::ST_QUEUED;
            end else begin
               r.status = dpdq_pkg::ST_DROPPED;
            end
         end
         dpdq_pkg::ACT_PROMOTE: begin
            if (pend_count == 0 || act_count >= lim) begin
               r.status = dpdq_pkg::ST_NO_PROMOTE;
            end else begin
               r.status = dpdq_pkg::ST_PROMOTED;
               r.handle = pend_handle[0];
               r.key = pend_key[0][31:0];
               r.key_present = pend_key[0][32];
               r.prio = pend_prio[0];
               if (act_count < A_DEPTH) begin
                  act_handle[act_count] = pend_handle[0];
                  act_key[act_count] = pend_key[0];
                  act_prio[act_count] = pend_prio[0];
                  act_count++;
               end
               for (int j = 1; j < pend_count; j++) begin
                  pend_handle[j-1] = pend_handle[j];
                  pend_key[j-1] = pend_key[j];
                  pend_prio[j-1] = pend_prio[j];
               end
               pend_count--;
            end
         end
         dpdq_pkg::ACT_REMOVE_A: begin
            w = 0;
            n = act_count;
            for (int i = 0; i < n; i++)
               if (act_handle[i] != rq.handle) begin
                  act_handle[w] = act_handle[i];
                  act_key[w] = act_key[i];
                  act_prio[w] = act_prio[i];
                  w++;
               end
            act_count = w;
            r.status = (w != n) ? dpdq_pkg::ST_REMOVED : dpdq_pkg::ST_NOT_FOUND;
         end
         dpdq_pkg::ACT_REMOVE_P: begin
            w = 0;
            n = pend_count;
            for (int i = 0; i < n; i++)
               if (pend_handle[i] != rq.handle) begin
                  pend_handle[w] = pend_handle[i];
                  pend_key[w] = pend_key[i];
                  pend_prio[w] = pend_prio[i];
                  w++;
               end
            pend_count = w;
            r.status = (w != n) ? dpdq_pkg::ST_REMOVED : dpdq_pkg::ST_NOT_FOUND;
         end
         dpdq_pkg::ACT_CLEAR: begin
            act_count = 0;
            pend_count = 0;
            r.status = dpdq_pkg::ST_CLEARED;
         end
         default: r.status = dpdq_pkg::ST_NOT_FOUND;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // drives one request, predicts it at the accepting edge
   task automatic send_request(request_type rq, bit typed = 1'b0,
                               logic [3:0] t_status = '0, logic [31:0] t_handle = '0);
      dpdq_pkg::result_type r;
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
      end
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.action = rq.act;
      req_ch.handle_id = rq.handle;
      req_ch.dedup_key = rq.key;
      req_ch.key_present = rq.key_present;
      req_ch.priority_req = rq.prio;
      do @(posedge clock); while (!req_ch.ready);
      r = predict_queue(rq);
      if (typed) begin
         r = '0;
         r.status = t_status;
         r.handle = t_handle;
      end
      expected_rsps.push_back(r);
   endtask

   task automatic release_request();
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   // waits until every expected response has come back
   task automatic drain();
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic write_visible(logic [31:0] value);
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = dpdq_pkg::REG_MAX_VISIBLE;
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      visible_cfg = value[3:0];
   endtask

   // random request: small pools of handles and keys so that hits happen
   function automatic request_type random_request();
      request_type rq;
      int pick;
      pick = $urandom_range(99);
      if (pick < 48) rq.act = dpdq_pkg::ACT_ADMIT;
      else if (pick < 70) rq.act = dpdq_pkg::ACT_PROMOTE;
      else if (pick < 83) rq.act = dpdq_pkg::ACT_REMOVE_A;
      else if (pick < 95) rq.act = dpdq_pkg::ACT_REMOVE_P;
      else if (pick < 97) rq.act = dpdq_pkg::ACT_CLEAR;
      else rq.act = 3'($urandom_range(7, 5));
      rq.handle = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(15));
      rq.key = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(11));
      rq.key_present = ($urandom_range(3) != 0);
      rq.prio = ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(3));
      return rq;
   endfunction

   // receiver: random stalls plus an optional long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready = 1'b0;
      end else begin
         rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // response check against the oldest expectation
   always @(posedge clock) begin
      dpdq_pkg::result_type want;
      cycles++;
      if (cycles > MAX_CYCLES) begin
         $display("[dedup_priority_display_queue] ERROR");
         $finish;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response status", 32'(rsp_ch.status), 32'hx);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
            if (rsp_ch.handle_out !== want.handle)
               report_mismatch("handle", rsp_ch.handle_out, want.handle);
            if (rsp_ch.key_out !== want.key)
               report_mismatch("key", rsp_ch.key_out, want.key);
            if (rsp_ch.key_present_out !== want.key_present)
               report_mismatch("key present", 32'(rsp_ch.key_present_out),
                               32'(want.key_present));
            if (rsp_ch.priority_out !== want.prio)
               report_mismatch("priority", 32'(rsp_ch.priority_out), 32'(want.prio));
         end
      end
   end

   row_type rows[$];
   int limits[8] = '{8, 0, 15, 3, 1, 5, 2, 8};

   initial begin
      req_ch.valid = 1'b0;
      req_ch.action = dpdq_pkg::ACT_ADMIT;
      req_ch.handle_id = '0;
      req_ch.dedup_key = '0;
      req_ch.key_present = 1'b0;
      req_ch.priority_req = '0;
      rsp_ch.ready = 1'b0;
      act_count = 0;
      pend_count = 0;
      visible_cfg = 4'd1;

      // directed part, limit of one after reset
      rows = '{
         '{'{dpdq_pkg::ACT_PROMOTE, 32'd0, 32'd0, 1'b0, 8'd0}, 1'b1,
           dpdq_pkg::ST_NO_PROMOTE, 32'd0},
         '{'{dpdq_pkg::ACT_REMOVE_A, 32'd5, 32'd0, 1'b0, 8'd0}, 1'b1,
           dpdq_pkg::ST_NOT_FOUND, 32'd0},
         '{'{dpdq_pkg::ACT_REMOVE_P, 32'd5, 32'd0, 1'b0, 8'd0}, 1'b1,
           dpdq_pkg::ST_NOT_FOUND, 32'd0},
         '{'{dpdq_pkg::ACT_ADMIT, 32'hffffffff, 32'hffffffff, 1'b1, 8'hff}, 1'b1,
           dpdq_pkg::ST_SHOWN, 32'd0},
         // same key in the active list
         '{'{dpdq_pkg::ACT_ADMIT, 32'd1, 32'hffffffff, 1'b1, 8'd0}, 1'b1,
           dpdq_pkg::ST_DEDUP_HIT, 32'hffffffff},
         // no key: never matches, goes pending
         '{'{dpdq_pkg::ACT_ADMIT, 32'd2, 32'hffffffff, 1'b0, 8'd0}, 1'b1,
           dpdq_pkg::ST_QUEUED, 32'd0},
         '{'{dpdq_pkg::ACT_ADMIT, 32'd3, 32'd0, 1'b0, 8'd0}, 1'b1,
           dpdq_pkg::ST_QUEUED, 32'd0},
         '{'{dpdq_pkg::ACT_ADMIT, 32'd4, 32'd0, 1'b1, 8'hff}, 1'b1,
           dpdq_pkg::ST_QUEUED, 32'd0},
         // same key in the pending list
         '{'{dpdq_pkg::ACT_ADMIT, 32'd5, 32'd0, 1'b1, 8'd7}, 1'b1,
           dpdq_pkg::ST_DEDUP_HIT, 32'd4},
         '{'{dpdq_pkg::ACT_ADMIT, 32'd6, 32'd7, 1'b1, 8'd0}, 1'b1,
           dpdq_pkg::ST_QUEUED, 32'd0},
         '{'{ACT_UNUSED_LO, 32'd4, 32'd1, 1'b1, 8'd1}, 1'b1,
           dpdq_pkg::ST_NOT_FOUND, 32'd0},
         '{'{ACT_UNUSED_HI, 32'd4, 32'd1, 1'b1, 8'd1}, 1'b1,
           dpdq_pkg::ST_NOT_FOUND, 32'd0},
         '{'{dpdq_pkg::ACT_PROMOTE, 32'd0, 32'd0, 1'b0, 8'd0}, 1'b1,
           dpdq_pkg::ST_NO_PROMOTE, 32'd0},
         '{'{dpdq_pkg::ACT_REMOVE_A, 32'hffffffff, 32'd0, 1'b0, 8'd0}, 1'b1,
           dpdq_pkg::ST_REMOVED, 32'd0},
         // pending head is the highest priority one
         '{'{dpdq_pkg::ACT_PROMOTE, 32'd0, 32'd0, 1'b0, 8'd0}, 1'b0,
           dpdq_pkg::ST_PROMOTED, 32'd0},
         '{'{dpdq_pkg::ACT_REMOVE_P, 32'd2, 32'd0, 1'b0, 8'd0}, 1'b1,
           dpdq_pkg::ST_REMOVED, 32'd0},
         '{'{dpdq_pkg::ACT_PROMOTE, 32'd0, 32'd0, 1'b0, 8'd0}, 1'b1,
           dpdq_pkg::ST_NO_PROMOTE, 32'd0},
         '{'{dpdq_pkg::ACT_CLEAR, 32'd0, 32'd0, 1'b0, 8'd0}, 1'b1,
           dpdq_pkg::ST_CLEARED, 32'd0},
         '{'{dpdq_pkg::ACT_PROMOTE, 32'd0, 32'd0, 1'b0, 8'd0}, 1'b1,
           dpdq_pkg::ST_NO_PROMOTE, 32'd0}
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].status,
                                     rows[i].handle);
      release_request();
      drain();

      // random phases: each sets a new limit and an idling mode
      for (int ph = 0; ph < 8; ph++) begin
         write_visible(limits[ph] | (ph[0] ? 32'hfffffff0 : 32'h0));
         case (ph % 4)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin sender_idle_pct = 11; recv_stall_pct = 11; end
         endcase
         // long receiver hold-off so the block fills and stalls its input
         if (ph == 4) begin
            @(posedge clock);
            hold_left = 400;
         end
         for (int n = 0; n < PHASE_REQS; n++) begin
            send_request(random_request());
            // pause mid phase until the block has answered everything
            if (ph == 6 && n == PHASE_REQS / 2) begin
               release_request();
               drain();
            end
         end
         release_request();
         drain();
      end

      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("[dedup_priority_display_queue] OK");
      else
         $display("[dedup_priority_display_queue] ERROR");
      $finish;
   end
endmodule
